[rtl/core/msgv_pkg.sv]
// Shared types and codes for the MessagePack value encoder.
// Used by msgv_encode, msgv_serializer and msgpack_value_encoder; no dependencies.
package msgv_pkg;

    // input opcodes
    localparam logic [3:0] OP_UINT    = 4'd0;
    localparam logic [3:0] OP_SINT    = 4'd1;
    localparam logic [3:0] OP_BOOL    = 4'd2;
    localparam logic [3:0] OP_CHAR    = 4'd3;
    localparam logic [3:0] OP_FLOAT32 = 4'd4;
    localparam logic [3:0] OP_FLOAT64 = 4'd5;
    localparam logic [3:0] OP_STR_HDR = 4'd6;
    localparam logic [3:0] OP_RAW     = 4'd7;
    localparam logic [3:0] OP_MAP_HDR = 4'd8;

    // MessagePack type bytes
    localparam logic [7:0] MP_FALSE   = 8'hC2;
    localparam logic [7:0] MP_TRUE    = 8'hC3;
    localparam logic [7:0] MP_FLOAT32 = 8'hCA;
    localparam logic [7:0] MP_FLOAT64 = 8'hCB;
    localparam logic [7:0] MP_UINT8   = 8'hCC;
    localparam logic [7:0] MP_UINT16  = 8'hCD;
    localparam logic [7:0] MP_UINT32  = 8'hCE;
    localparam logic [7:0] MP_UINT64  = 8'hCF;
    localparam logic [7:0] MP_INT8    = 8'hD0;
    localparam logic [7:0] MP_INT16   = 8'hD1;
    localparam logic [7:0] MP_INT32   = 8'hD2;
    localparam logic [7:0] MP_INT64   = 8'hD3;
    localparam logic [7:0] MP_STR8    = 8'hD9;
    localparam logic [7:0] MP_STR16   = 8'hDA;
    localparam logic [7:0] MP_STR32   = 8'hDB;
    localparam logic [7:0] MP_MAP16   = 8'hDE;
    localparam logic [7:0] MP_MAP32   = 8'hDF;
    localparam logic [7:0] MP_FIXSTR  = 8'hA0;
    localparam logic [7:0] MP_FIXMAP  = 8'h80;
    localparam logic [7:0] MP_FIXSTR1 = 8'hA1;

    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned FRAME_W     = FRAME_BYTES * 8;

    // one encoded item: bytes left-aligned, first byte in the top lane
    typedef struct packed {
        logic [3:0]         count;
        logic [FRAME_W-1:0] frame;
    } enc_t;

endpackage

[rtl/core/msgv_encode.sv]
// Combinational encoder: opcode and value to a left-aligned byte frame.
// Depends on msgv_pkg.
module msgv_encode (
    input  logic [3:0]     opcode,
    input  logic [63:0]    value,
    output msgv_pkg::enc_t enc
);

    logic [31:0] len;

    function automatic msgv_pkg::enc_t one(input logic [7:0] b);
        msgv_pkg::enc_t r;
        r.count = 4'd1;
        r.frame = {b, 64'd0};
        return r;
    endfunction

    function automatic msgv_pkg::enc_t hdr1(input logic [7:0] h, input logic [63:0] v);
        msgv_pkg::enc_t r;
        r.count = 4'd2;
        r.frame = {h, v[7:0], 56'd0};
        return r;
    endfunction

    function automatic msgv_pkg::enc_t hdr2(input logic [7:0] h, input logic [63:0] v);
        msgv_pkg::enc_t r;
        r.count = 4'd3;
        r.frame = {h, v[15:0], 48'd0};
        return r;
    endfunction

    function automatic msgv_pkg::enc_t hdr4(input logic [7:0] h, input logic [63:0] v);
        msgv_pkg::enc_t r;
        r.count = 4'd5;
        r.frame = {h, v[31:0], 32'd0};
        return r;
    endfunction

    function automatic msgv_pkg::enc_t hdr8(input logic [7:0] h, input logic [63:0] v);
        msgv_pkg::enc_t r;
        r.count = 4'd9;
        r.frame = {h, v};
        return r;
    endfunction

    function automatic msgv_pkg::enc_t enc_uint(input logic [63:0] v);
        msgv_pkg::enc_t r;
        if (v <= 64'h7F)
            r = one(v[7:0]);
        else if (v <= 64'hFF)
            r = hdr1(msgv_pkg::MP_UINT8, v);
        else if (v <= 64'hFFFF)
            r = hdr2(msgv_pkg::MP_UINT16, v);
        else if (v <= 64'hFFFF_FFFF)
            r = hdr4(msgv_pkg::MP_UINT32, v);
        else
            r = hdr8(msgv_pkg::MP_UINT64, v);
        return r;
    endfunction

    // v has its sign bit set; minus thirty-two goes to int8
    function automatic msgv_pkg::enc_t enc_neg(input logic [63:0] v);
        msgv_pkg::enc_t r;
        if (v >= 64'hFFFF_FFFF_FFFF_FFE1)
            r = one(v[7:0]);
        else if (v >= 64'hFFFF_FFFF_FFFF_FF80)
            r = hdr1(msgv_pkg::MP_INT8, v);
        else if (v >= 64'hFFFF_FFFF_FFFF_8000)
            r = hdr2(msgv_pkg::MP_INT16, v);
        else if (v >= 64'hFFFF_FFFF_8000_0000)
            r = hdr4(msgv_pkg::MP_INT32, v);
        else
            r = hdr8(msgv_pkg::MP_INT64, v);
        return r;
    endfunction

    assign len = value[31:0];

    always_comb
    begin
        enc.count = 4'd0;
        enc.frame = '0;
        unique case (opcode)
            msgv_pkg::OP_UINT:    enc = enc_uint(value);
            msgv_pkg::OP_SINT:    enc = value[63] ? enc_neg(value) : enc_uint(value);
            msgv_pkg::OP_BOOL:    enc = one((|value) ? msgv_pkg::MP_TRUE : msgv_pkg::MP_FALSE);
            msgv_pkg::OP_CHAR:    enc = hdr1(msgv_pkg::MP_FIXSTR1, value);
            msgv_pkg::OP_FLOAT32: enc = hdr4(msgv_pkg::MP_FLOAT32, value);
            msgv_pkg::OP_FLOAT64: enc = hdr8(msgv_pkg::MP_FLOAT64, value);
            msgv_pkg::OP_STR_HDR:
            begin
                if (len < 32'd32)
                    enc = one(msgv_pkg::MP_FIXSTR | {3'b000, len[4:0]});
                else if (len <= 32'hFF)
                    enc = hdr1(msgv_pkg::MP_STR8, {32'd0, len});
                else if (len <= 32'hFFFF)
                    enc = hdr2(msgv_pkg::MP_STR16, {32'd0, len});
                else
                    enc = hdr4(msgv_pkg::MP_STR32, {32'd0, len});
            end
            msgv_pkg::OP_RAW:     enc = one(value[7:0]);
            msgv_pkg::OP_MAP_HDR:
            begin
                if (len <= 32'hF)
                    enc = one(msgv_pkg::MP_FIXMAP | {4'b0000, len[3:0]});
                else if (len <= 32'hFFFF)
                    enc = hdr2(msgv_pkg::MP_MAP16, {32'd0, len});
                else
                    enc = hdr4(msgv_pkg::MP_MAP32, {32'd0, len});
            end
            default:
            begin
                // undefined opcodes emit nothing
                enc.count = 4'd0;
                enc.frame = '0;
            end
        endcase
    end

endmodule

[rtl/core/msgv_serializer.sv]
// Frame register that sends an encoded item out one byte per word.
// Depends on msgv_pkg.
module msgv_serializer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  msgv_pkg::enc_t enc,
    output logic           free,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           last_byte
);

    logic [3:0]                   cnt_reg;
    logic [3:0]                   cnt_next;
    logic [msgv_pkg::FRAME_W-1:0] frame_reg;
    logic [msgv_pkg::FRAME_W-1:0] frame_next;
    logic                         pop;

    assign out_valid = (cnt_reg != 4'd0);
    assign out_byte  = frame_reg[msgv_pkg::FRAME_W-1 -: 8];
    assign last_byte = (cnt_reg == 4'd1);
    assign pop       = out_valid && out_ready;
    // can take a new frame when empty or the last word leaves this cycle
    assign free      = !out_valid || (last_byte && out_ready);

    always_comb
    begin
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        if (load)
        begin
            cnt_next   = enc.count;
            frame_next = enc.frame;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 4'd1;
            frame_next = {frame_reg[msgv_pkg::FRAME_W-9:0], 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

[rtl/core/msgpack_value_encoder.sv]
// Top level of the MessagePack value encoder: input register, encoder, serializer.
// Depends on msgv_pkg, msgv_encode and msgv_serializer.
//
// Each accepted word (opcode, value) is held in an input register, encoded
// combinationally, and its MessagePack bytes leave big-endian, one byte per output
// word, with last_byte set on the final one. An item is one to nine bytes (type
// byte plus 0, 1, 2, 4 or 8 payload bytes). The next item is taken while the current
// one is still being sent and is handed to the serializer in the cycle its final
// byte leaves, so bytes flow without gaps. Undefined opcodes (9 to 15) produce no
// output. From accept, the word passes the input register and then the serializer's
// frame register before its first byte is shown.
module msgpack_value_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  opcode,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    logic           full_reg;
    logic           full_next;
    logic [3:0]     op_reg;
    logic [63:0]    val_reg;
    logic           ser_free;
    logic           load;
    msgv_pkg::enc_t enc;

    assign load     = full_reg && ser_free;
    assign in_ready = !full_reg || ser_free;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
            full_next = 1'b1;
        else if (load)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode;
            val_reg <= value;
        end
    end

    msgv_encode u_encode (
        .opcode (op_reg),
        .value  (val_reg),
        .enc    (enc)
    );

    msgv_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .enc       (enc),
        .free      (ser_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule
